// ===== hdl/bhmm_pkg.sv =====
// shared types, widths and codes for the binned histogram mode mean block
package bhmm_pkg;

  // field widths
  localparam int ValueW     = 20;
  localparam int CountW     = 16;
  localparam int BinWidthW  = 16;
  localparam int PctW       = 7;
  localparam int BinsUsedW  = 7;
  localparam int CfgIdxW    = 2;

  // default table size
  localparam int TableDepthDef = 64;

  // register reset values and limits
  localparam logic [BinWidthW-1:0] BinWidthRst = 16'd10;
  localparam logic [PctW-1:0]      PctRst      = 7'd50;
  localparam logic [CountW-1:0]    CountMax    = 16'hFFFF;
  localparam logic [BinsUsedW-1:0] BinsUsedMax = 7'd127;
  localparam int                   PctFull     = 100;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegBinWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegIncludePct = 2'd1;

  // operation codes
  localparam logic OpAdd     = 1'b0;
  localparam logic OpCompute = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_DIV,
    ST_ADD_SCAN,
    ST_CMP_PREP,
    ST_CMP_CHECK,
    ST_CMP_SCAN,
    ST_CMP_MUL,
    ST_CMP_ACC,
    ST_CMP_DIV,
    ST_CMP_OUT
  } state_e;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hdl/bhmm_div.sv =====
// restoring divider, one quotient bit per cycle, shared by binning and mean
module bhmm_div #(
  parameter int DividendW = 42,
  parameter int DivisorW  = 23
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [DividendW-1:0]          dividend_i,
  input  logic [DivisorW-1:0]           divisor_i,
  output bhmm_pkg::div_stat_t           stat_o,
  output logic [bhmm_pkg::ValueW-1:0]   quot_o,
  output logic [DivisorW-1:0]           rem_o
);

  localparam int QW   = bhmm_pkg::ValueW;
  localparam int CntW = $clog2(QW + 1);

  logic                busy_q;
  logic                done_q;
  logic [CntW-1:0]     cnt_q;
  logic [DivisorW-1:0] rem_q;
  logic [DivisorW-1:0] divisor_q;
  logic [QW-1:0]       lo_q;

  logic [DivisorW:0]   trial;
  logic [DivisorW:0]   diff;
  logic                fits;

  // one shift-subtract step
  always_comb begin
    trial = {rem_q, lo_q[QW-1]};
    diff  = trial - {1'b0, divisor_q};
    fits  = trial >= {1'b0, divisor_q};
  end

  // step counter and status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // partial remainder and quotient shift register
  // the upper dividend bits are known to be below the divisor
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= dividend_i[DividendW-1:QW];
      lo_q      <= dividend_i[QW-1:0];
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
      lo_q  <= {lo_q[QW-2:0], fits};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = lo_q;
  assign rem_o       = rem_q;

endmodule

// ===== hdl/binned_histogram_mode_mean.sv =====
// Add: a divide by the bin width, then a scan of the open bins through the registered memory read port.
// Compute: per included bin one scan of all open bins, then a divide of the weighted sum by the count.
// One item is in work at a time.
// The result sits in an output register; a compute waits there only if it is still held.
// Reset: bin width 10, include percent 50, histogram empty, drop flag clear.
// Bin memory contents are not cleared; only entries below the open-bin count are read.
module binned_histogram_mode_mean #(
  parameter int TABLE_DEPTH = bhmm_pkg::TableDepthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             operation_i,
  input  logic [bhmm_pkg::ValueW-1:0]      sample_us_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [bhmm_pkg::ValueW-1:0]      mean_us_o,
  output logic [bhmm_pkg::CountW-1:0]      samples_total_o,
  output logic [bhmm_pkg::BinsUsedW-1:0]   bins_used_o,
  output logic                             dropped_o,
  // configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bhmm_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [bhmm_pkg::BinWidthW-1:0]   cfg_data_i
);

  localparam int VW  = bhmm_pkg::ValueW;
  localparam int CW  = bhmm_pkg::CountW;
  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int NW  = $clog2(TABLE_DEPTH + 1);
  localparam int TW  = CW + NW;
  localparam int SW  = VW + CW + NW;
  localparam int PW  = TW + bhmm_pkg::PctW;
  localparam int LW  = TW + 8;
  localparam int NXW = (NW > bhmm_pkg::BinsUsedW) ? NW : bhmm_pkg::BinsUsedW;

  bhmm_pkg::state_e state_q, state_d;

  // configuration
  logic [bhmm_pkg::BinWidthW-1:0] width_q;
  logic [bhmm_pkg::PctW-1:0]      pct_q;
  logic [bhmm_pkg::BinWidthW-1:0] width_eff;

  // histogram bookkeeping
  logic [NW-1:0] n_q;
  logic [TW-1:0] total_q;
  logic          drop_q;

  // bin memories
  logic [VW-1:0] mem_val [TABLE_DEPTH];
  logic [CW-1:0] mem_cnt [TABLE_DEPTH];
  logic [VW-1:0] rd_val_q;
  logic [CW-1:0] rd_cnt_q;
  logic          rd_en;
  logic          we_val, we_cnt;
  logic [AW-1:0] waddr;
  logic [VW-1:0] wval;
  logic [CW-1:0] wcnt;

  // scan pipeline
  logic [NW-1:0] scan_q;
  logic          dv_q;
  logic [AW-1:0] didx_q;
  logic          scan_init;
  logic          scan_done;

  // add path
  logic [VW-1:0] sample_q;
  logic [VW-1:0] bin_v_q;
  logic          add_match;

  // compute path
  logic          found_q;
  logic [AW-1:0] best_idx_q;
  logic [CW-1:0] best_cnt_q;
  logic [VW-1:0] best_val_q;
  logic          cmp_take;
  logic [PW-1:0] tp_q;
  logic [TW-1:0] counted_q;
  logic [SW-1:0] sum_q;
  logic [NW-1:0] picked_q;
  logic [VW+CW-1:0] prod_q;
  logic [LW-1:0] need_lhs;
  logic          below_target;
  logic          pick_more;
  logic [VW-1:0] mean_q;

  // divider
  logic                div_start;
  logic [SW-1:0]       div_dividend;
  logic [TW-1:0]       div_divisor;
  bhmm_pkg::div_stat_t div_stat;
  logic [VW-1:0]       div_quot;
  logic [TW-1:0]       div_rem;

  // handshakes
  logic in_acc;
  logic out_free;
  logic [NXW-1:0] n_ext;

  assign in_stall_o  = (state_q != bhmm_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_o || !out_stall_i;
  assign width_eff   = (width_q == '0) ? bhmm_pkg::BinWidthW'(1) : width_q;

  // scan status and compare results
  always_comb begin
    scan_done    = !dv_q && (scan_q >= n_q);
    add_match    = dv_q && (rd_val_q == bin_v_q);
    cmp_take     = dv_q && (rd_cnt_q != '0) && (!found_q || rd_cnt_q >= best_cnt_q);
    rd_en        = ((state_q == bhmm_pkg::ST_ADD_SCAN) || (state_q == bhmm_pkg::ST_CMP_SCAN))
                   && (scan_q < n_q);
    // counted < floor(total*pct/100) written as 100*(counted+1) <= total*pct
    need_lhs     = LW'(counted_q) * LW'(bhmm_pkg::PctFull) + LW'(bhmm_pkg::PctFull);
    below_target = need_lhs <= LW'(tp_q);
    pick_more    = (picked_q < n_q) && ((picked_q == '0) || below_target);
    n_ext        = NXW'(n_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bhmm_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = (operation_i == bhmm_pkg::OpAdd) ? bhmm_pkg::ST_ADD_DIV
                                                     : bhmm_pkg::ST_CMP_PREP;
        end
      end
      bhmm_pkg::ST_ADD_DIV: begin
        if (div_stat.done) state_d = bhmm_pkg::ST_ADD_SCAN;
      end
      bhmm_pkg::ST_ADD_SCAN: begin
        if (add_match || scan_done) state_d = bhmm_pkg::ST_IDLE;
      end
      bhmm_pkg::ST_CMP_PREP: begin
        state_d = bhmm_pkg::ST_CMP_CHECK;
      end
      bhmm_pkg::ST_CMP_CHECK: begin
        if (pick_more) begin
          state_d = bhmm_pkg::ST_CMP_SCAN;
        end else if (counted_q != '0) begin
          state_d = bhmm_pkg::ST_CMP_DIV;
        end else begin
          state_d = bhmm_pkg::ST_CMP_OUT;
        end
      end
      bhmm_pkg::ST_CMP_SCAN: begin
        if (scan_done) state_d = bhmm_pkg::ST_CMP_MUL;
      end
      bhmm_pkg::ST_CMP_MUL: begin
        state_d = bhmm_pkg::ST_CMP_ACC;
      end
      bhmm_pkg::ST_CMP_ACC: begin
        state_d = bhmm_pkg::ST_CMP_CHECK;
      end
      bhmm_pkg::ST_CMP_DIV: begin
        if (div_stat.done) state_d = bhmm_pkg::ST_CMP_OUT;
      end
      bhmm_pkg::ST_CMP_OUT: begin
        if (out_free) state_d = bhmm_pkg::ST_IDLE;
      end
      default: state_d = bhmm_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: divider launch and memory writes
  always_comb begin
    div_start    = 1'b0;
    div_dividend = sum_q;
    div_divisor  = counted_q;
    we_val       = 1'b0;
    we_cnt       = 1'b0;
    waddr        = didx_q;
    wval         = bin_v_q;
    wcnt         = '0;
    case (state_q)
      bhmm_pkg::ST_IDLE: begin
        div_dividend = SW'(sample_us_i);
        div_divisor  = TW'(width_eff);
        div_start    = in_acc && (operation_i == bhmm_pkg::OpAdd);
      end
      bhmm_pkg::ST_ADD_SCAN: begin
        if (add_match) begin
          we_cnt = 1'b1;
          wcnt   = (rd_cnt_q == bhmm_pkg::CountMax) ? rd_cnt_q : rd_cnt_q + CW'(1);
        end else if (scan_done && (n_q < NW'(TABLE_DEPTH))) begin
          we_cnt = 1'b1;
          we_val = 1'b1;
          waddr  = n_q[AW-1:0];
          wcnt   = CW'(1);
        end
      end
      bhmm_pkg::ST_CMP_CHECK: begin
        div_start = !pick_more && (counted_q != '0);
      end
      bhmm_pkg::ST_CMP_MUL: begin
        // a zero count marks the bin as already taken
        we_cnt = 1'b1;
        waddr  = best_idx_q;
        wcnt   = '0;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign scan_init = (state_q != state_d) &&
                     ((state_d == bhmm_pkg::ST_ADD_SCAN) || (state_d == bhmm_pkg::ST_CMP_SCAN));

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bhmm_pkg::ST_IDLE;
      width_q     <= bhmm_pkg::BinWidthRst;
      pct_q       <= bhmm_pkg::PctRst;
      n_q         <= '0;
      total_q     <= '0;
      drop_q      <= 1'b0;
      scan_q      <= '0;
      dv_q        <= 1'b0;
      found_q     <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;

      // register writes
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          bhmm_pkg::RegBinWidth:   width_q <= cfg_data_i;
          bhmm_pkg::RegIncludePct: pct_q   <= cfg_data_i[bhmm_pkg::PctW-1:0];
          default:                 width_q <= width_q;
        endcase
      end

      // scan address and data-valid pipeline
      if (scan_init) begin
        scan_q  <= '0;
        dv_q    <= 1'b0;
        found_q <= 1'b0;
      end else if (rd_en) begin
        scan_q <= scan_q + NW'(1);
        dv_q   <= 1'b1;
      end else begin
        dv_q <= 1'b0;
      end
      if ((state_q == bhmm_pkg::ST_CMP_SCAN) && cmp_take) found_q <= 1'b1;

      // add bookkeeping
      if (state_q == bhmm_pkg::ST_ADD_SCAN) begin
        if (add_match) begin
          if (rd_cnt_q != bhmm_pkg::CountMax) total_q <= total_q + TW'(1);
        end else if (scan_done) begin
          if (n_q < NW'(TABLE_DEPTH)) begin
            n_q     <= n_q + NW'(1);
            total_q <= total_q + TW'(1);
          end else begin
            drop_q <= 1'b1;
          end
        end
      end

      // result beat and histogram clear
      if ((state_q == bhmm_pkg::ST_CMP_OUT) && out_free) begin
        out_valid_o <= 1'b1;
        n_q         <= '0;
        total_q     <= '0;
        drop_q      <= 1'b0;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // bin memories, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_val) mem_val[waddr] <= wval;
    if (we_cnt) mem_cnt[waddr] <= wcnt;
    if (rd_en) begin
      rd_val_q <= mem_val[scan_q[AW-1:0]];
      rd_cnt_q <= mem_cnt[scan_q[AW-1:0]];
      didx_q   <= scan_q[AW-1:0];
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) sample_q <= sample_us_i;

    // round down to a multiple of the bin width
    if ((state_q == bhmm_pkg::ST_ADD_DIV) && div_stat.done) begin
      bin_v_q <= sample_q - VW'(div_rem[bhmm_pkg::BinWidthW-1:0]);
    end

    // largest remaining count, later bin wins a tie
    if ((state_q == bhmm_pkg::ST_CMP_SCAN) && cmp_take) begin
      best_idx_q <= didx_q;
      best_cnt_q <= rd_cnt_q;
      best_val_q <= rd_val_q;
    end

    case (state_q)
      bhmm_pkg::ST_CMP_PREP: begin
        tp_q      <= PW'(total_q) * PW'(pct_q);
        counted_q <= '0;
        sum_q     <= '0;
        picked_q  <= '0;
        mean_q    <= '0;
      end
      bhmm_pkg::ST_CMP_MUL: begin
        prod_q <= best_val_q * best_cnt_q;
      end
      bhmm_pkg::ST_CMP_ACC: begin
        sum_q     <= sum_q + SW'(prod_q);
        counted_q <= counted_q + TW'(best_cnt_q);
        picked_q  <= picked_q + NW'(1);
      end
      bhmm_pkg::ST_CMP_DIV: begin
        if (div_stat.done) mean_q <= div_quot;
      end
      default: begin
        prod_q <= prod_q;
      end
    endcase

    // result payload
    if ((state_q == bhmm_pkg::ST_CMP_OUT) && out_free) begin
      mean_us_o       <= mean_q;
      samples_total_o <= (total_q > TW'(bhmm_pkg::CountMax)) ? bhmm_pkg::CountMax
                                                             : total_q[CW-1:0];
      bins_used_o     <= (n_ext > NXW'(bhmm_pkg::BinsUsedMax)) ? bhmm_pkg::BinsUsedMax
                                                               : n_ext[bhmm_pkg::BinsUsedW-1:0];
      dropped_o       <= drop_q;
    end
  end

  // shared divider: sample modulo bin width, then weighted sum over count
  bhmm_div #(
    .DividendW (SW),
    .DivisorW  (TW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // open bins never exceed the table
  assert property (@(posedge clk_i) disable iff (!rst_ni) n_q <= NW'(TABLE_DEPTH))
    else $error("open bin count beyond table depth");

  // an empty histogram holds no samples
  assert property (@(posedge clk_i) disable iff (!rst_ni) (n_q == '0) |-> (total_q == '0))
    else $error("sample total nonzero with no open bins");

  // divider is idle whenever a new beat can be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni) !in_stall_o |-> !div_stat.busy)
    else $error("divider busy while accepting input");

  // divider finishes only in a state that waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> ((state_q == bhmm_pkg::ST_ADD_DIV) || (state_q == bhmm_pkg::ST_CMP_DIV)))
    else $error("divider done outside a divide state");

endmodule
